// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge, held off while reset is low.
`define BPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bpc assertion failed");

// Check a property at every rising clock edge, reset included.
`define BPC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bpc assertion failed");

`endif

// ----- hw/rtl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, constants and helpers shared by the pressure compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int unsigned DataW = 64;

  localparam logic [63:0] TFineOffset = 64'd128000;
  localparam logic [20:0] PressBase   = 21'd1048576;
  localparam logic [63:0] PressScale  = 64'd3125;
  localparam logic [63:0] DivOne      = 64'h0000_8000_0000_0000;  // 1 << 47

  typedef enum logic [2:0] {
    REG_T1    = 3'd0,
    REG_T2    = 3'd1,
    REG_T3    = 3'd2,
    REG_P1    = 3'd3,
    REG_P2_P3 = 3'd4,
    REG_P4_P5 = 3'd5,
    REG_P6_P7 = 3'd6,
    REG_P8_P9 = 3'd7
  } bpc_reg_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } bpc_cal_t;

  // Work handed from front end to back end.
  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic [31:0] tfine;
  } bpc_job_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/baro_pressure_compensation.sv -----
// ----------------------------------------------------------------------------
// baro_pressure_compensation
// Integer compensation of raw barometer readings to Q24.8 pascals.
// ----------------------------------------------------------------------------
// Push one raw 20-bit temperature and one raw 20-bit pressure reading; pop one
// result holding the fine temperature, the compensated pressure in unsigned
// Q24.8 pascals (negative values clamp to 0, values above 32 bits clamp to all
// ones) and a flag that marks a zero divisor, in which case the pressure is 0.
// Load the twelve calibration words through the APB port first (register i at
// byte address 4*i, the pressure words packed in pairs) and rewrite them only
// while no transfer is in flight. The back end divides at one quotient bit per
// cycle, then makes three passes through its own multiplier (a job with a zero
// divisor skips both), taking the job in its idle state and loading the result
// in its output state, which waits for the result slot to be free. The front
// end makes ten passes through its own multiplier. One reading can wait in the
// input slot and two jobs in the middle queue while a finished result waits to
// be popped.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_pressure_compensation
  import bpc_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input queue side
  input  wire logic         push,
  output logic              full,
  input  wire logic [19:0]  raw_temperature_i,
  input  wire logic [19:0]  raw_pressure_i,
  // result queue side
  output logic              empty,
  input  wire logic         pop,
  output logic [31:0]       pressure_q24_8_o,
  output logic [31:0]       fine_temperature_o,
  output logic              divide_by_zero_o,
  // calibration registers
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0] t1_q, t2_q, t3_q, p1_q;
  logic [31:0] p23_q, p45_q, p67_q, p89_q;
  bpc_reg_e    idx;
  bpc_cal_t    cal;
  logic        cfg_wr;

  logic     job_wr, job_full, job_rd, job_empty;
  bpc_job_t job_in, job_out;

  assign pready = 1'b1;
  assign idx    = bpc_reg_e'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  // Store calibration words on a completed write transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q  <= '0;
      t2_q  <= '0;
      t3_q  <= '0;
      p1_q  <= '0;
      p23_q <= '0;
      p45_q <= '0;
      p67_q <= '0;
      p89_q <= '0;
    end else if (cfg_wr) begin
      case (idx)
        REG_T1:    t1_q  <= pwdata[15:0];
        REG_T2:    t2_q  <= pwdata[15:0];
        REG_T3:    t3_q  <= pwdata[15:0];
        REG_P1:    p1_q  <= pwdata[15:0];
        REG_P2_P3: p23_q <= pwdata;
        REG_P4_P5: p45_q <= pwdata;
        REG_P6_P7: p67_q <= pwdata;
        REG_P8_P9: p89_q <= pwdata;
        default:   t1_q  <= t1_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_T1:    prdata = {16'd0, t1_q};
      REG_T2:    prdata = {16'd0, t2_q};
      REG_T3:    prdata = {16'd0, t3_q};
      REG_P1:    prdata = {16'd0, p1_q};
      REG_P2_P3: prdata = p23_q;
      REG_P4_P5: prdata = p45_q;
      REG_P6_P7: prdata = p67_q;
      REG_P8_P9: prdata = p89_q;
      default:   prdata = '0;
    endcase
  end

  // Unpack the paired pressure words.
  assign cal.t1 = t1_q;
  assign cal.t2 = t2_q;
  assign cal.t3 = t3_q;
  assign cal.p1 = p1_q;
  assign cal.p2 = p23_q[15:0];
  assign cal.p3 = p23_q[31:16];
  assign cal.p4 = p45_q[15:0];
  assign cal.p5 = p45_q[31:16];
  assign cal.p6 = p67_q[15:0];
  assign cal.p7 = p67_q[31:16];
  assign cal.p8 = p89_q[15:0];
  assign cal.p9 = p89_q[31:16];

  // Front end: take the reading, run the temperature and divisor math.
  bpc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cal_i             (cal),
    .push              (push),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .full              (full),
    .job_wr_o          (job_wr),
    .job_o             (job_in),
    .job_full_i        (job_full)
  );

  // Decouple the two halves so each can stall on its own.
  bpc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_wr),
    .wr_data_i (job_in),
    .full_o    (job_full),
    .rd_i      (job_rd),
    .rd_data_o (job_out),
    .empty_o   (job_empty)
  );

  // Back end: divide, finish the pressure terms, hold the result.
  bpc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cal_i              (cal),
    .job_empty_i        (job_empty),
    .job_i              (job_out),
    .job_rd_o           (job_rd),
    .pop                (pop),
    .empty              (empty),
    .pressure_q24_8_o   (pressure_q24_8_o),
    .fine_temperature_o (fine_temperature_o),
    .divide_by_zero_o   (divide_by_zero_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/bpc_mul.sv -----
// ----------------------------------------------------------------------------
// bpc_mul
// Low 64 bits of a 64x64 product, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_mul
  import bpc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DataW-1:0]  a_i,
  input  wire logic [DataW-1:0]  b_i,
  output logic                   done_o,
  output logic [DataW-1:0]       p_o
);

  logic [63:0] a_q, b_q, acc_q;
  logic [1:0]  step_q;
  logic        done_q;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  always_comb begin
    ma = (step_q == 2'd3) ? a_q[63:32] : a_q[31:0];
    mb = (step_q == 2'd2) ? b_q[63:32] : b_q[31:0];
  end

  assign prod = 64'(ma) * 64'(mb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= (step_q == 2'd3);
      if (start_i) begin
        step_q <= 2'd1;
      end else if (step_q != 2'd0) begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (step_q == 2'd1) begin
      acc_q <= prod;
    end else if (step_q != 2'd0) begin
      // cross terms only reach the upper word
      acc_q <= acc_q + {prod[31:0], 32'd0};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bpc_fifo.sv -----
// ----------------------------------------------------------------------------
// bpc_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_fifo
  import bpc_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_i,
  input  wire bpc_job_t  wr_data_i,
  output logic           full_o,
  input  wire logic      rd_i,
  output bpc_job_t       rd_data_o,
  output logic           empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  bpc_job_t           mem_q [Depth];
  logic [AddrW-1:0]   wp_q, rp_q;
  logic [CntW-1:0]    cnt_q;
  logic               do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == AddrW'(Depth - 1)) ? '0 : wp_q + AddrW'(1);
      end
      if (do_rd) begin
        rp_q <= (rp_q == AddrW'(Depth - 1)) ? '0 : rp_q + AddrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bpc_front.sv -----
// ----------------------------------------------------------------------------
// bpc_front
// Accept raw readings; form fine temperature, dividend and divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_front
  import bpc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire bpc_cal_t     cal_i,
  input  wire logic         push,
  input  wire logic [19:0]  raw_temperature_i,
  input  wire logic [19:0]  raw_pressure_i,
  output logic              full,
  output logic              job_wr_o,
  output bpc_job_t          job_o,
  input  wire logic         job_full_i
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_ISSUE = 4'b0010,
    F_WAIT  = 4'b0100,
    F_PUSH  = 4'b1000
  } bpc_fstate_e;

  typedef enum logic [3:0] {
    OP_TA  = 4'd0,
    OP_DD  = 4'd1,
    OP_TF  = 4'd2,
    OP_SQ  = 4'd3,
    OP_V2A = 4'd4,
    OP_V2B = 4'd5,
    OP_X   = 4'd6,
    OP_Y   = 4'd7,
    OP_DEN = 4'd8,
    OP_NUM = 4'd9
  } bpc_fop_e;

  bpc_fstate_e  st_q;
  bpc_fop_e     op_q;
  logic         slot_q;
  logic [19:0]  slot_t_q, slot_p_q, wt_q, wp_q;
  logic [63:0]  a_q, dd_q, v1_q, sq_q, v2_q, x_q, y_q, den_q, num_q;
  logic [31:0]  tf_q;

  logic [17:0]        ta;
  logic [16:0]        dt;
  logic [20:0]        pp;
  logic [63:0]        mul_a, mul_b, mul_p, tf_sum;
  logic signed [63:0] ms;
  logic [63:0]        sh8, sh11, sh12, sh14, sh33;
  logic               mul_done;

  assign full = slot_q;
  assign ta   = {1'b0, wt_q[19:3]} - {1'b0, cal_i.t1, 1'b0};
  assign dt   = {1'b0, wt_q[19:4]} - {1'b0, cal_i.t1};
  assign pp   = PressBase - {1'b0, wp_q};

  assign ms   = mul_p;
  assign sh8  = ms >>> 8;
  assign sh11 = ms >>> 11;
  assign sh12 = ms >>> 12;
  assign sh14 = ms >>> 14;
  assign sh33 = ms >>> 33;
  assign tf_sum = a_q + sh14;

  always_comb begin
    mul_a = v1_q;
    mul_b = v1_q;
    case (op_q)
      OP_TA:  begin mul_a = {{46{ta[17]}}, ta}; mul_b = sx16(cal_i.t2); end
      OP_DD:  begin mul_a = {{47{dt[16]}}, dt}; mul_b = {{47{dt[16]}}, dt}; end
      OP_TF:  begin mul_a = dd_q; mul_b = sx16(cal_i.t3); end
      OP_SQ:  begin mul_a = v1_q; mul_b = v1_q; end
      OP_V2A: begin mul_a = sq_q; mul_b = sx16(cal_i.p6); end
      OP_V2B: begin mul_a = v1_q; mul_b = sx16(cal_i.p5); end
      OP_X:   begin mul_a = sq_q; mul_b = sx16(cal_i.p3); end
      OP_Y:   begin mul_a = v1_q; mul_b = sx16(cal_i.p2); end
      OP_DEN: begin mul_a = y_q;  mul_b = {48'd0, cal_i.p1}; end
      OP_NUM: begin mul_a = ({43'd0, pp} << 31) - v2_q; mul_b = PressScale; end
      default: begin mul_a = v1_q; mul_b = v1_q; end
    endcase
  end

  bpc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == F_ISSUE),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      op_q   <= OP_TA;
      slot_q <= 1'b0;
    end else begin
      if (push && !slot_q) begin
        slot_q <= 1'b1;
      end
      case (st_q)
        F_IDLE: begin
          if (slot_q) begin
            slot_q <= 1'b0;
            op_q   <= OP_TA;
            st_q   <= F_ISSUE;
          end
        end
        F_ISSUE: st_q <= F_WAIT;
        F_WAIT: begin
          if (mul_done) begin
            if (op_q == OP_NUM) begin
              st_q <= F_PUSH;
            end else begin
              op_q <= bpc_fop_e'(op_q + 4'd1);
              st_q <= F_ISSUE;
            end
          end
        end
        F_PUSH: begin
          if (!job_full_i) begin
            st_q <= F_IDLE;
          end
        end
        default: st_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !slot_q) begin
      slot_t_q <= raw_temperature_i;
      slot_p_q <= raw_pressure_i;
    end
    if (st_q == F_IDLE && slot_q) begin
      wt_q <= slot_t_q;
      wp_q <= slot_p_q;
    end
    if (st_q == F_WAIT && mul_done) begin
      case (op_q)
        OP_TA:  a_q  <= sh11;
        OP_DD:  dd_q <= sh12;
        OP_TF: begin
          tf_q <= tf_sum[31:0];
          v1_q <= tf_sum - TFineOffset;
        end
        OP_SQ:  sq_q <= mul_p;
        OP_V2A: v2_q <= mul_p;
        OP_V2B: v2_q <= v2_q + (mul_p << 17) + (sx16(cal_i.p4) << 35);
        OP_X:   x_q  <= sh8;
        OP_Y:   y_q  <= DivOne + x_q + (mul_p << 12);
        OP_DEN: den_q <= sh33;
        OP_NUM: num_q <= mul_p;
        default: num_q <= mul_p;
      endcase
    end
  end

  assign job_wr_o  = (st_q == F_PUSH);
  assign job_o.num   = num_q;
  assign job_o.den   = den_q;
  assign job_o.tfine = tf_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bpc_back.sv -----
// ----------------------------------------------------------------------------
// bpc_back
// Divide, apply the second-order pressure terms, clamp, hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_back
  import bpc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire bpc_cal_t     cal_i,
  input  wire logic         job_empty_i,
  input  wire bpc_job_t     job_i,
  output logic              job_rd_o,
  input  wire logic         pop,
  output logic              empty,
  output logic [31:0]       pressure_q24_8_o,
  output logic [31:0]       fine_temperature_o,
  output logic              divide_by_zero_o
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_DIV   = 5'b00010,
    B_ISSUE = 5'b00100,
    B_WAIT  = 5'b01000,
    B_OUT   = 5'b10000
  } bpc_bstate_e;

  typedef enum logic [1:0] {
    OP_E9 = 2'd0,
    OP_SQ = 2'd1,
    OP_P8 = 2'd2
  } bpc_bop_e;

  bpc_bstate_e st_q;
  bpc_bop_e    op_q;
  logic [63:0] rem_q, quo_q, ud_q, q_q, m_q, ta_q, s_q;
  logic [5:0]  cnt_q;
  logic        neg_q, dz_q, out_vld_q;
  logic [31:0] tf_q;

  logic [63:0]        trial, quo_nx, mul_a, mul_b, mul_p, e13, sh19, sh25, r;
  logic signed [63:0] ms, qs, ss;
  logic               ge, mul_done, load_out;
  logic [31:0]        clamp;

  assign trial  = {rem_q[62:0], quo_q[63]};
  assign ge     = (trial >= ud_q);
  assign quo_nx = {quo_q[62:0], ge};

  assign ms   = mul_p;
  assign qs   = q_q;
  assign ss   = s_q;
  assign e13  = qs >>> 13;
  assign sh19 = ms >>> 19;
  assign sh25 = ms >>> 25;
  assign r    = 64'(ss >>> 8) + (sx16(cal_i.p7) << 4);

  always_comb begin
    if (r[63]) begin
      clamp = 32'd0;
    end else if (|r[63:32]) begin
      clamp = 32'hFFFF_FFFF;
    end else begin
      clamp = r[31:0];
    end
  end

  always_comb begin
    case (op_q)
      OP_E9:   begin mul_a = sx16(cal_i.p9); mul_b = e13; end
      OP_SQ:   begin mul_a = m_q;            mul_b = e13; end
      OP_P8:   begin mul_a = sx16(cal_i.p8); mul_b = q_q; end
      default: begin mul_a = m_q;            mul_b = q_q; end
    endcase
  end

  bpc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == B_ISSUE),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign job_rd_o = (st_q == B_IDLE) && !job_empty_i;
  assign load_out = (st_q == B_OUT) && (!out_vld_q || pop);
  assign empty    = !out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= B_IDLE;
      op_q      <= OP_E9;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
      case (st_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            cnt_q <= '0;
            op_q  <= OP_E9;
            st_q  <= (job_i.den == '0) ? B_OUT : B_DIV;
          end
        end
        B_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            st_q <= B_ISSUE;
          end
        end
        B_ISSUE: st_q <= B_WAIT;
        B_WAIT: begin
          if (mul_done) begin
            if (op_q == OP_P8) begin
              st_q <= B_OUT;
            end else begin
              op_q <= bpc_bop_e'(op_q + 2'd1);
              st_q <= B_ISSUE;
            end
          end
        end
        B_OUT: begin
          if (load_out) begin
            st_q <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_rd_o) begin
      tf_q  <= job_i.tfine;
      dz_q  <= (job_i.den == '0);
      neg_q <= job_i.num[63] ^ job_i.den[63];
      rem_q <= '0;
      quo_q <= job_i.num[63] ? (64'd0 - job_i.num) : job_i.num;
      ud_q  <= job_i.den[63] ? (64'd0 - job_i.den) : job_i.den;
    end else if (st_q == B_DIV) begin
      rem_q <= ge ? (trial - ud_q) : trial;
      quo_q <= quo_nx;
      if (cnt_q == 6'd63) begin
        q_q <= neg_q ? (64'd0 - quo_nx) : quo_nx;
      end
    end
    if (st_q == B_WAIT && mul_done) begin
      case (op_q)
        OP_E9:   m_q  <= mul_p;
        OP_SQ:   ta_q <= sh25;
        OP_P8:   s_q  <= q_q + ta_q + sh19;
        default: m_q  <= mul_p;
      endcase
    end
    if (load_out) begin
      pressure_q24_8_o   <= dz_q ? 32'd0 : clamp;
      fine_temperature_o <= tf_q;
      divide_by_zero_o   <= dz_q;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bpc_checker.sv -----
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks for the pressure compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bpc_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         push,
  input wire logic         full,
  input wire logic         empty,
  input wire logic         pop,
  input wire logic [31:0]  pressure_q24_8_o,
  input wire logic         divide_by_zero_o,
  input wire logic         pready
);

  `BPC_ASSERT_ALWAYS(a_pready_high, clk_i, pready)
  `BPC_ASSERT(a_dz_zero, clk_i, rst_ni, (!empty && divide_by_zero_o) |-> (pressure_q24_8_o == 32'd0))
  `BPC_ASSERT(a_slot_holds, clk_i, rst_ni, (push && !full) |=> full)
  `BPC_ASSERT(a_result_holds, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(pressure_q24_8_o)))

endmodule

bind baro_pressure_compensation bpc_checker u_bpc_checker (.*);

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the barometric pressure compensation block: loads
// calibration sets over APB, pushes raw readings with random gaps, pops the
// results with random stalls and compares each against an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
  import bpc_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 300;
  localparam int unsigned RandItems     = 1350;

  typedef struct {
    logic [31:0] pressure;
    logic [31:0] tfine;
    logic        dz;
  } comp_result_t;

  typedef struct {
    logic [19:0] temp;
    logic [19:0] press;
    bit          typed;      // expected value given in the row
    logic [31:0] pressure;
    logic [31:0] tfine;
    logic        dz;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [19:0] raw_temperature_i = '0;
  logic [19:0] raw_pressure_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [31:0] pressure_q24_8_o;
  logic [31:0] fine_temperature_o;
  logic divide_by_zero_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  baro_pressure_compensation DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Calibration mirror as written to the registers; compensate() unpacks it to signed 64-bit words.
  logic [15:0] cal_t1, cal_t2, cal_t3, cal_p1;
  logic [31:0] cal_p23, cal_p45, cal_p67, cal_p89;

  comp_result_t pending_results[$];
  int unsigned  fail_count = 0;
  int unsigned  idle_cycles = 0;

  function automatic logic signed [63:0] sext16(logic [15:0] v);
    return $signed({{48{v[15]}}, v});
  endfunction

  // Compensate one reading with the current calibration mirror.
  function automatic comp_result_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
    comp_result_t r;
    logic signed [63:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] a, b, d, tf, v1, v2, p, num, q;
    logic [63:0] un, ud;
    bit neg;
    t2 = sext16(cal_t2); t3 = sext16(cal_t3);
    p2 = sext16(cal_p23[15:0]); p3 = sext16(cal_p23[31:16]);
    p4 = sext16(cal_p45[15:0]); p5 = sext16(cal_p45[31:16]);
    p6 = sext16(cal_p67[15:0]); p7 = sext16(cal_p67[31:16]);
    p8 = sext16(cal_p89[15:0]); p9 = sext16(cal_p89[31:16]);
    a = (($signed({44'd0, adc_t >> 3}) - $signed({47'd0, cal_t1, 1'b0})) * t2) >>> 11;
    d = $signed({44'd0, adc_t >> 4}) - $signed({48'd0, cal_t1});
    b = (((d * d) >>> 12) * t3) >>> 14;
    tf = a + b;
    v1 = tf - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * $signed({48'd0, cal_p1})) >>> 33;
    r.tfine = tf[31:0];
    r.dz = (v1 == 0);
    r.pressure = '0;
    if (!r.dz) begin
      p = 64'sd1048576 - $signed({44'd0, adc_p});
      num = ((p <<< 31) - v2) * 64'sd3125;
      neg = num[63] ^ v1[63];
      un = num[63] ? -num : num;
      ud = v1[63] ? -v1 : v1;
      q = $signed(un / ud);
      p = neg ? -q : q;
      a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      b = (p8 * p) >>> 19;
      p = ((p + a + b) >>> 8) + (p7 <<< 4);
      if (p[63]) r.pressure = '0;
      else if (p[63:32] != 0) r.pressure = '1;
      else r.pressure = p[31:0];
    end
    return r;
  endfunction

  // One APB write: setup cycle, then access cycle.
  task automatic apb_write(bpc_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_T1:    cal_t1 = val[15:0];
      REG_T2:    cal_t2 = val[15:0];
      REG_T3:    cal_t3 = val[15:0];
      REG_P1:    cal_p1 = val[15:0];
      REG_P2_P3: cal_p23 = val;
      REG_P4_P5: cal_p45 = val;
      REG_P6_P7: cal_p67 = val;
      default:   cal_p89 = val;
    endcase
  endtask

  task automatic load_cal(logic [15:0] t1, t2, t3, p1, logic [31:0] p23, p45, p67, p89);
    apb_write(REG_T1, {16'd0, t1});
    apb_write(REG_T2, {16'd0, t2});
    apb_write(REG_T3, {16'd0, t3});
    apb_write(REG_P1, {16'd0, p1});
    apb_write(REG_P2_P3, p23);
    apb_write(REG_P4_P5, p45);
    apb_write(REG_P6_P7, p67);
    apb_write(REG_P8_P9, p89);
  endtask

  // Drop push, hold off until every expected transfer is back, then settle.
  task automatic drain;
    push <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Push one reading after a random gap; record its expectation.
  task automatic push_item(logic [19:0] t, logic [19:0] pr, comp_result_t exp_r);
    int unsigned gap;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1; raw_temperature_i <= t; raw_pressure_i <= pr;
    do @(posedge clk_i); while (full);
    pending_results.push_back(exp_r);
  endtask

  task automatic push_rand(int unsigned n);
    logic [19:0] t, pr;
    repeat (n) begin
      // Mostly realistic readings, some full-range noise.
      if ($urandom_range(0, 3) != 0) begin
        t = 20'($urandom_range(400000, 600000));
        pr = 20'($urandom_range(250000, 450000));
      end else begin
        t = 20'($urandom); pr = 20'($urandom);
      end
      push_item(t, pr, compensate(t, pr));
    end
  endtask

  // Pop side: random stall per result, compare against the oldest expectation.
  initial begin : result_side
    comp_result_t want;
    int unsigned  stall;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (pressure_q24_8_o !== want.pressure) begin
            $error("pressure_q24_8 exp %0h got %0h", want.pressure, pressure_q24_8_o);
            fail_count++;
          end
          if (fine_temperature_o !== want.tfine) begin
            $error("fine_temperature exp %0h got %0h", want.tfine, fine_temperature_o);
            fail_count++;
          end
          if (divide_by_zero_o !== want.dz) begin
            $error("divide_by_zero exp %0b got %0b", want.dz, divide_by_zero_o);
            fail_count++;
          end
        end
        stall = $urandom_range(0, 10);
        if (stall != 0) begin
          pop <= 1'b0;
          repeat (stall) @(posedge clk_i);
          pop <= 1'b1;
        end
      end else if (!pop) begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles without any accepted transfer.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  stim_row_t dir_rows[$];

  initial begin : stimulus
    cal_t1 = '0; cal_t2 = '0; cal_t3 = '0; cal_p1 = '0;
    cal_p23 = '0; cal_p45 = '0; cal_p67 = '0; cal_p89 = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // After reset every word is zero: tfine 0, divisor 0.
    dir_rows.push_back('{20'h00000, 20'h00000, 1, 32'd0, 32'd0, 1'b1});
    dir_rows.push_back('{20'hFFFFF, 20'hFFFFF, 1, 32'd0, 32'd0, 1'b1});
    foreach (dir_rows[i])
      push_item(dir_rows[i].temp, dir_rows[i].press,
                '{dir_rows[i].pressure, dir_rows[i].tfine, dir_rows[i].dz});
    drain();

    // Typical calibration; field extremes and mid values.
    load_cal(16'd27504, 16'd26435, 16'hFC18, 16'd36477,
             {16'hF93C, 16'hD6D0}, {16'hFF9C, 16'h0B27}, {16'h3C70, 16'hFFF9},
             {16'h1770, 16'hC3FD});
    dir_rows.delete();
    dir_rows.push_back('{20'h00000, 20'h00000, 0, '0, '0, 0});
    dir_rows.push_back('{20'hFFFFF, 20'hFFFFF, 0, '0, '0, 0});
    dir_rows.push_back('{20'h00000, 20'hFFFFF, 0, '0, '0, 0});
    dir_rows.push_back('{20'hFFFFF, 20'h00000, 0, '0, '0, 0});
    dir_rows.push_back('{20'd519888, 20'd415148, 0, '0, '0, 0});
    dir_rows.push_back('{20'hAAAAA, 20'h55555, 0, '0, '0, 0});
    dir_rows.push_back('{20'h55555, 20'hAAAAA, 0, '0, '0, 0});
    foreach (dir_rows[i])
      push_item(dir_rows[i].temp, dir_rows[i].press,
                compensate(dir_rows[i].temp, dir_rows[i].press));
    drain();

    // Extreme calibration words: wrap, clamp high/low, division overflow paths.
    load_cal(16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF,
             32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_7FFF, 32'h7FFF_7FFF);
    foreach (dir_rows[i])
      push_item(dir_rows[i].temp, dir_rows[i].press,
                compensate(dir_rows[i].temp, dir_rows[i].press));
    drain();
    load_cal(16'h0000, 16'h8000, 16'h7FFF, 16'h0001,
             32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_8000, 32'h8000_8000);
    foreach (dir_rows[i])
      push_item(dir_rows[i].temp, dir_rows[i].press,
                compensate(dir_rows[i].temp, dir_rows[i].press));
    drain();

    // Random phases: realistic sets mostly, a fully random set in every third phase.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph % 3 == 2)
        load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 $urandom, $urandom, $urandom, $urandom);
      else
        load_cal(16'($urandom_range(26000, 29000)), 16'($urandom_range(25000, 27500)),
                 16'hFC18 + 16'($urandom_range(0, 50)), 16'($urandom_range(35000, 38000)),
                 {16'hF93C + 16'($urandom_range(0, 200)), 16'hD6D0 + 16'($urandom_range(0, 500))},
                 {16'hFF9C + 16'($urandom_range(0, 20)), 16'h0B27 + 16'($urandom_range(0, 800))},
                 {16'h3C70 - 16'($urandom_range(0, 300)), 16'hFFF9 + 16'($urandom_range(0, 5))},
                 {16'h1770 - 16'($urandom_range(0, 500)), 16'hC3FD + 16'($urandom_range(0, 900))});
      push_rand(RandItems / 9);
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
